// ===== rtl/lbpe_pkg.sv =====
`default_nettype none
package lbpe_pkg;

  localparam int MaxColors = 8;
  localparam int PassLimit = 16;
  localparam int FadeScale = 10;

  localparam logic [3:0] PH_DISABLED   = 4'd0;
  localparam logic [3:0] PH_BLINK_ON   = 4'd1;
  localparam logic [3:0] PH_ON         = 4'd2;
  localparam logic [3:0] PH_BLINK_OFF  = 4'd3;
  localparam logic [3:0] PH_OFF        = 4'd4;
  localparam logic [3:0] PH_BEGIN_GAP  = 4'd5;
  localparam logic [3:0] PH_IN_GAP     = 4'd6;
  localparam logic [3:0] PH_BEGIN_DASH = 4'd7;
  localparam logic [3:0] PH_IN_DASH    = 4'd8;
  localparam logic [3:0] PH_BEGIN_GAP2 = 4'd9;
  localparam logic [3:0] PH_IN_GAP2    = 4'd10;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [2:0] REG_ON     = 3'd0;
  localparam logic [2:0] REG_OFF    = 3'd1;
  localparam logic [2:0] REG_GAP    = 3'd2;
  localparam logic [2:0] REG_DASH   = 3'd3;
  localparam logic [2:0] REG_GROUP  = 3'd4;
  localparam logic [2:0] REG_BLEND  = 3'd5;
  localparam logic [2:0] REG_FADE   = 3'd6;
  localparam logic [2:0] REG_COLORS = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic start;    // latch item, do write
    logic restart;  // restart pattern
    logic fade;     // fade step check
    logic visit;    // one phase visit
    logic finish;   // end-of-tick counter bumps
  } lbpe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       visit_done;  // visit returned
    logic       pass_end;    // visit closed a pass without returning
    logic [1:0] op;
  } lbpe_stat_t;

  function automatic logic [7:0] step_ch(input logic [7:0] cur, input logic [7:0] tgt,
                                         input logic [7:0] rate);
    logic [7:0] d;
    d = 8'd0;
    if (cur < tgt) begin
      d = tgt - cur;
      return cur + ((d > rate) ? rate : d);
    end else if (cur > tgt) begin
      d = cur - tgt;
      return cur - ((d > rate) ? rate : d);
    end
    return cur;
  endfunction

  // (pos + 1) mod n for n in 1..8, restoring compare and subtract
  function automatic logic [2:0] next_slot(input logic [2:0] pos, input logic [3:0] n);
    logic [6:0] x;
    x = 7'(pos) + 7'd1;
    if (x >= {n, 3'b000}) x = x - {n, 3'b000};
    if (x >= {1'b0, n, 2'b00}) x = x - {1'b0, n, 2'b00};
    if (x >= {2'b00, n, 1'b0}) x = x - {2'b00, n, 1'b0};
    if (x >= {3'b000, n}) x = x - {3'b000, n};
    return x[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbpe_ctrl.sv =====
`default_nettype none
module lbpe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire lbpe_pkg::lbpe_stat_t stat,
  output lbpe_pkg::lbpe_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_FADE = 5'b00100,
    S_PLAY = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [4:0] pass, pass_next;
  logic [4:0] pass_sum;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // passes completed so far, counting the visit of the previous cycle
  assign pass_sum = pass + {4'd0, stat.pass_end};

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op == lbpe_pkg::OP_TICK) begin
          state_next = S_FADE;
        end else if (stat.op == lbpe_pkg::OP_RESTART || stat.op == lbpe_pkg::OP_WRITE) begin
          cmd.restart = 1'b1;
          state_next  = S_OUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FADE: begin
        cmd.fade   = 1'b1;
        pass_next  = '0;
        state_next = S_PLAY;
      end
      S_PLAY: begin
        if (stat.visit_done || pass_sum == 5'(lbpe_pkg::PassLimit)) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.visit = 1'b1;
          pass_next = pass_sum;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

`ifndef SYNTH
  a_out_only_after_work: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> in_stall) else $error("accepted while busy");
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.visit |-> pass < 5'(lbpe_pkg::PassLimit)) else $error("pass overrun");
`endif

endmodule
`default_nettype wire

// ===== rtl/lbpe_dp.sv =====
`default_nettype none
module lbpe_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lbpe_pkg::lbpe_cmd_t cmd,
  output lbpe_pkg::lbpe_stat_t   stat,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_idx,
  input  wire logic [7:0]        cfg_data,
  input  wire logic [1:0]        opcode,
  input  wire logic [2:0]        slot,
  input  wire logic [7:0]        red_in,
  input  wire logic [7:0]        green_in,
  input  wire logic [7:0]        blue_in,
  output logic [7:0]             led_red,
  output logic [7:0]             led_green,
  output logic [7:0]             led_blue,
  output logic [3:0]             phase,
  output logic [7:0]             fade_level
);

  logic [7:0] on_time, off_time, gap_time, dash_time, group_length, blend_rate, fade_period;
  logic [3:0] color_count;

  logic [1:0]  op;
  logic [3:0]  phase_reg, phase_next;
  logic [7:0]  group_left, group_next;
  logic [2:0]  color_pos, pos_next;
  logic        pos_valid, valid_next;
  logic [23:0] color_table [lbpe_pkg::MaxColors];
  logic [7:0]  hold_ticks, hold_next, elapsed, elapsed_next;
  logic [11:0] fade_cnt, fade_cnt_next;
  logic [8:0]  fade_step, fade_step_next;
  logic [7:0]  fade_off, fade_off_next;
  logic [23:0] bcur, bcur_next, btgt, btgt_next, led, led_next;
  logic        done, pass_end;
  logic        visit_ret, loop_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_time <= '0; off_time <= '0; gap_time <= '0; dash_time <= '0;
      group_length <= '0; blend_rate <= '0; fade_period <= '0; color_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lbpe_pkg::REG_ON:     on_time <= cfg_data;
        lbpe_pkg::REG_OFF:    off_time <= cfg_data;
        lbpe_pkg::REG_GAP:    gap_time <= cfg_data;
        lbpe_pkg::REG_DASH:   dash_time <= cfg_data;
        lbpe_pkg::REG_GROUP:  group_length <= cfg_data;
        lbpe_pkg::REG_BLEND:  blend_rate <= cfg_data;
        lbpe_pkg::REG_FADE:   fade_period <= cfg_data;
        lbpe_pkg::REG_COLORS: color_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0]  ncol;
  logic [11:0] fade_limit;
  assign ncol       = (color_count > 4'(lbpe_pkg::MaxColors)) ? 4'(lbpe_pkg::MaxColors)
                                                              : color_count;
  assign fade_limit = 12'(fade_period) * 12'(lbpe_pkg::FadeScale);

  assign stat.visit_done = done;
  assign stat.pass_end   = pass_end;
  assign stat.op         = op;

  assign led_red    = led[23:16];
  assign led_green  = led[15:8];
  assign led_blue   = led[7:0];
  assign phase      = phase_reg;
  assign fade_level = fade_off;

  always_comb begin
    logic [23:0] nc;
    logic [7:0]  r, g, b;
    logic [8:0]  m;
    logic [7:0]  reload;
    logic [3:0]  p;
    nc = '0; r = '0; g = '0; b = '0; m = '0;
    visit_ret = 1'b0; loop_end = 1'b0;
    reload = (group_length != 8'd0) ? group_length
           : 8'(ncol) - ((dash_time != 8'd0) ? 8'd1 : 8'd0);
    phase_next = phase_reg; group_next = group_left; pos_next = color_pos;
    valid_next = pos_valid; hold_next = hold_ticks; elapsed_next = elapsed;
    fade_cnt_next = fade_cnt; fade_step_next = fade_step; fade_off_next = fade_off;
    bcur_next = bcur; btgt_next = btgt; led_next = led;
    p = phase_reg;

    if (cmd.restart) begin
      valid_next = 1'b0; pos_next = '0;
      fade_cnt_next = '0; fade_step_next = '0; fade_off_next = '0;
      phase_next = (dash_time != 8'd0) ? lbpe_pkg::PH_BEGIN_DASH : lbpe_pkg::PH_BLINK_ON;
      if ((on_time == 8'd0 && dash_time == 8'd0) || ncol == 4'd0)
        phase_next = lbpe_pkg::PH_DISABLED;
      group_next = reload;
      // color_count nonzero here whenever reads matter; ncol==0 gives black, no move
      if (ncol != 4'd0 && (blend_rate != 8'd0 || fade_period != 8'd0)) begin
        valid_next = 1'b1;
        pos_next   = '0;
        if (blend_rate != 8'd0) begin
          bcur_next = color_table[0];
          pos_next  = (ncol == 4'd1) ? 3'd0 : 3'd1;
          btgt_next = color_table[pos_next];
        end
      end else if (ncol == 4'd0 && blend_rate != 8'd0) begin
        bcur_next = '0; btgt_next = '0;
      end
    end

    if (cmd.fade && fade_period != 8'd0 && fade_cnt >= fade_limit) begin
      fade_cnt_next = '0;
      m = fade_step + 9'd1;
      if (m >= {off_time, 1'b0}) m = '0;
      fade_step_next = m;
      if (off_time == 8'd0) begin
        fade_off_next = '0;
      end else begin
        fade_off_next = (m < {1'b0, off_time}) ? m[7:0] : 8'({off_time, 1'b0} - m - 9'd1);
        if (m == 9'd0 && ncol != 4'd0) begin
          pos_next   = !pos_valid ? 3'd0 : lbpe_pkg::next_slot(color_pos, ncol);
          valid_next = 1'b1;
        end
      end
    end

    if (cmd.visit) begin
      // next_color value from current position
      if (ncol != 4'd0) begin
        pos_next = !pos_valid ? 3'd0 : lbpe_pkg::next_slot(color_pos, ncol);
        nc       = color_table[pos_next];
      end
      unique case (p)
        lbpe_pkg::PH_DISABLED: begin
          pos_next = color_pos;
          visit_ret = 1'b1;
        end
        lbpe_pkg::PH_BLINK_ON: begin
          pos_next = color_pos;
          if (on_time != 8'd0) begin
            if (blend_rate != 8'd0) begin
              btgt_next = btgt;
              if (bcur == btgt) begin
                if (ncol != 4'd0) begin
                  pos_next = !pos_valid ? 3'd0 : lbpe_pkg::next_slot(color_pos, ncol);
                  valid_next = 1'b1;
                end
                btgt_next = nc;
              end
              r = lbpe_pkg::step_ch(bcur[23:16], btgt_next[23:16], blend_rate);
              g = lbpe_pkg::step_ch(bcur[15:8],  btgt_next[15:8],  blend_rate);
              b = lbpe_pkg::step_ch(bcur[7:0],   btgt_next[7:0],   blend_rate);
              bcur_next = {r, g, b};
              led_next  = {r, g, b};
            end else if (fade_period != 8'd0) begin
              led_next = (pos_valid && 4'(color_pos) < ncol) ? color_table[color_pos] : '0;
            end else begin
              if (ncol != 4'd0) begin
                pos_next = !pos_valid ? 3'd0 : lbpe_pkg::next_slot(color_pos, ncol);
                valid_next = 1'b1;
              end
              led_next = nc;
            end
            group_next = group_left - 8'd1;
            hold_next = on_time + fade_off; elapsed_next = '0;
            phase_next = lbpe_pkg::PH_ON; visit_ret = 1'b1;
          end else begin
            phase_next = lbpe_pkg::PH_BLINK_OFF;
          end
        end
        lbpe_pkg::PH_BLINK_OFF: begin
          pos_next = color_pos;
          phase_next = lbpe_pkg::PH_BEGIN_GAP;
          if (group_left > 8'd0 || (gap_time == 8'd0 && dash_time == 8'd0)) begin
            if (off_time != 8'd0) begin
              led_next = '0; hold_next = off_time - fade_off; elapsed_next = '0;
              phase_next = lbpe_pkg::PH_OFF; visit_ret = 1'b1;
            end else if (group_left > 8'd0 && on_time != 8'd0) begin
              phase_next = lbpe_pkg::PH_BLINK_ON;
              loop_end = 1'b1;
            end
          end
        end
        lbpe_pkg::PH_BEGIN_GAP: begin
          pos_next = color_pos;
          group_next = reload;
          if (gap_time != 8'd0) begin
            led_next = '0; hold_next = gap_time; elapsed_next = '0;
            phase_next = lbpe_pkg::PH_IN_GAP; visit_ret = 1'b1;
          end else begin
            phase_next = lbpe_pkg::PH_BEGIN_DASH;
          end
        end
        lbpe_pkg::PH_BEGIN_DASH: begin
          if (dash_time != 8'd0) begin
            if (ncol != 4'd0) valid_next = 1'b1;
            else pos_next = color_pos;
            led_next = nc; hold_next = dash_time; elapsed_next = '0;
            phase_next = lbpe_pkg::PH_IN_DASH; visit_ret = 1'b1;
          end else begin
            pos_next = color_pos;
            phase_next = lbpe_pkg::PH_BEGIN_GAP2;
          end
        end
        lbpe_pkg::PH_BEGIN_GAP2: begin
          pos_next = color_pos;
          if (dash_time != 8'd0 && gap_time != 8'd0) begin
            led_next = '0; hold_next = gap_time; elapsed_next = '0;
            phase_next = lbpe_pkg::PH_IN_GAP2; visit_ret = 1'b1;
          end else begin
            phase_next = lbpe_pkg::PH_BLINK_ON;
            loop_end = 1'b1;
          end
        end
        default: begin
          pos_next = color_pos;
          if (p > lbpe_pkg::PH_IN_GAP2) begin
            phase_next = lbpe_pkg::PH_DISABLED; visit_ret = 1'b1;
          end else if (hold_ticks == 8'd0 || elapsed < hold_ticks) begin
            visit_ret = 1'b1;
          end else begin
            elapsed_next = '0;
            loop_end = 1'b1;
            if (p == lbpe_pkg::PH_IN_GAP2 || (p == lbpe_pkg::PH_OFF && group_left > 8'd0))
              phase_next = (on_time != 8'd0) ? lbpe_pkg::PH_BLINK_ON
                         : ((dash_time != 8'd0) ? lbpe_pkg::PH_BEGIN_DASH
                                                : lbpe_pkg::PH_BEGIN_GAP);
            else if (p == lbpe_pkg::PH_OFF)
              phase_next = lbpe_pkg::PH_BEGIN_GAP;
            else
              phase_next = p + 4'd1;
          end
        end
      endcase
    end

    if (cmd.finish) begin
      if (fade_cnt < 12'd4095) fade_cnt_next = fade_cnt + 12'd1;
      if (elapsed < 8'd255) elapsed_next = elapsed + 8'd1;
    end
  end

  // per-visit return and pass flags; cleared at fade step of each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0; pass_end <= 1'b0;
    end else if (cmd.fade) begin
      done <= 1'b0; pass_end <= 1'b0;
    end else if (cmd.visit) begin
      done <= visit_ret; pass_end <= loop_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= lbpe_pkg::OP_TICK;
      for (int i = 0; i < lbpe_pkg::MaxColors; i++) color_table[i] <= '0;
    end else if (cmd.start) begin
      op <= opcode;
      if (opcode == lbpe_pkg::OP_WRITE) color_table[slot] <= {red_in, green_in, blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= lbpe_pkg::PH_DISABLED; group_left <= '0; color_pos <= '0;
      pos_valid <= 1'b0; hold_ticks <= '0; elapsed <= '0; fade_cnt <= '0;
      fade_step <= '0; fade_off <= '0; bcur <= '0; btgt <= '0; led <= '0;
    end else begin
      phase_reg <= phase_next; group_left <= group_next; color_pos <= pos_next;
      pos_valid <= valid_next; hold_ticks <= hold_next; elapsed <= elapsed_next;
      fade_cnt <= fade_cnt_next; fade_step <= fade_step_next; fade_off <= fade_off_next;
      bcur <= bcur_next; btgt <= btgt_next; led <= led_next;
    end
  end

`ifndef SYNTH
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> $stable(phase_reg) && $stable(led)) else $error("state moved on accept");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_reg <= lbpe_pkg::PH_IN_GAP2) else $error("phase out of range");
  a_restart_fade: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> fade_off == 8'd0 && fade_cnt == 12'd0) else $error("restart fade");
`endif

endmodule
`default_nettype wire

// ===== rtl/led_blink_pattern_engine_unit.sv =====
`default_nettype none
// LED blink-pattern engine. Each input item (tick, restart, no-op, or colour write
// then restart) yields one result with the colour shown, phase and fade offset. A
// restart, write or no-op goes from the decode state to the output state; a tick
// goes through decode, the fade step and the play state with its phase visits. The
// next item is taken in the cycle after the result leaves. A tick walks at most 16
// passes of up to five phase-loop visits each, so at most 80 visits. The user must
// write configuration via cfg_we/cfg_idx/cfg_data only while idle; not enforced.
module led_blink_pattern_engine_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [2:0] slot,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      led_red,
  output logic [7:0]      led_green,
  output logic [7:0]      led_blue,
  output logic [3:0]      phase,
  output logic [7:0]      fade_level
);

  lbpe_pkg::lbpe_cmd_t  cmd;
  lbpe_pkg::lbpe_stat_t stat;

  lbpe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  lbpe_dp u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data, .opcode, .slot,
    .red_in, .green_in, .blue_in, .led_red, .led_green, .led_blue, .phase, .fade_level
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_led_blink_pattern_engine_unit.sv =====
`default_nettype none
module tb_led_blink_pattern_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] slot;
    logic [7:0] r, g, b;
  } blink_cmd_t;

  typedef struct packed {
    logic [7:0] r, g, b;
    logic [3:0] ph;
    logic [7:0] fade;
  } led_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [2:0] slot = '0;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] led_red, led_green, led_blue, fade_level;
  logic [3:0] phase;

  led_blink_pattern_engine_unit DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [7:0] m_on, m_off, m_gap, m_dash, m_group, m_blend, m_fadep;
  logic [3:0] m_ncol;
  logic [3:0] p_phase;
  logic [7:0] p_group_left;
  logic [3:0] p_pos;
  logic       p_pos_ok;
  logic [23:0] p_table [lbpe_pkg::MaxColors];
  logic [7:0] p_hold, p_elapsed;
  logic [11:0] p_ftick;
  logic [8:0] p_fstep;
  logic [7:0] p_foff;
  logic [23:0] p_bcur, p_btgt, p_led;

  blink_cmd_t pending_items[$];
  led_state_t expected_leds[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 0;
  longint cycles = 0;

  function automatic int colors_in_use();
    return (m_ncol > lbpe_pkg::MaxColors) ? lbpe_pkg::MaxColors : int'(m_ncol);
  endfunction

  function automatic logic [23:0] advance_color();
    int n;
    n = colors_in_use();
    if (n == 0) return 24'd0;
    if (!p_pos_ok) p_pos = 0;
    else p_pos = 4'((int'(p_pos) + 1) % n);
    p_pos_ok = 1;
    return p_table[p_pos[2:0]];
  endfunction

  function automatic logic [23:0] shown_color();
    if (!p_pos_ok || int'(p_pos) >= colors_in_use()) return 24'd0;
    return p_table[p_pos[2:0]];
  endfunction

  function automatic logic [7:0] group_reload_val();
    if (m_group != 0) return m_group;
    return 8'(colors_in_use() - (m_dash != 0 ? 1 : 0));
  endfunction

  function automatic logic [7:0] chan_step(logic [7:0] c, logic [7:0] t);
    logic [7:0] d;
    if (c < t) begin
      d = t - c;
      return c + ((d > m_blend) ? m_blend : d);
    end
    if (c > t) begin
      d = c - t;
      return c - ((d > m_blend) ? m_blend : d);
    end
    return c;
  endfunction

  task automatic light_blink();
    if (m_blend != 0) begin
      if (p_bcur == p_btgt) p_btgt = advance_color();
      p_bcur = {chan_step(p_bcur[23:16], p_btgt[23:16]), chan_step(p_bcur[15:8], p_btgt[15:8]),
                chan_step(p_bcur[7:0], p_btgt[7:0])};
      p_led = p_bcur;
    end else if (m_fadep != 0) p_led = shown_color();
    else p_led = advance_color();
  endtask

  task automatic arm_hold(int ticks);
    p_hold = 8'(ticks);
    p_elapsed = 0;
    p_phase = p_phase + 4'd1;
  endtask

  task automatic restart_pattern();
    p_pos_ok = 0;
    p_pos = 0;
    p_ftick = 0;
    p_fstep = 0;
    p_phase = (m_dash != 0) ? lbpe_pkg::PH_BEGIN_DASH : lbpe_pkg::PH_BLINK_ON;
    if ((m_on == 0 && m_dash == 0) || colors_in_use() == 0) p_phase = lbpe_pkg::PH_DISABLED;
    p_group_left = group_reload_val();
    if (m_blend != 0) begin
      p_bcur = advance_color();
      p_btgt = advance_color();
    end else if (m_fadep != 0) void'(advance_color());
    p_foff = 0;
  endtask

  task automatic fade_step();
    int dur, range, m;
    dur = int'(m_fadep) * lbpe_pkg::FadeScale;
    range = m_off;
    if (int'(p_ftick) < dur) return;
    p_ftick = 0;
    m = int'(p_fstep) + 1;
    if (m >= 2 * range) m = 0;
    p_fstep = 9'(m);
    if (range == 0) begin
      p_foff = 0;
      return;
    end
    p_foff = 8'((m < range) ? m : 2 * range - m - 1);
    if (m == 0) void'(advance_color());
  endtask

  // phase walk for one tick; returns when a timed phase is armed or holding, when disabled, or at the pass limit
  task automatic walk_phases();
    int pass;
    logic [3:0] ph;
    for (pass = 0; pass < lbpe_pkg::PassLimit; pass++) begin
      ph = p_phase;
      if (ph == lbpe_pkg::PH_DISABLED) return;
      if (ph == lbpe_pkg::PH_BLINK_ON) begin
        if (m_on != 0) begin
          light_blink();
          p_group_left = p_group_left - 8'd1;
          arm_hold(int'(m_on) + int'(p_foff));
          return;
        end
        p_phase = lbpe_pkg::PH_BLINK_OFF;
        ph = lbpe_pkg::PH_BLINK_OFF;
      end
      if (ph == lbpe_pkg::PH_BLINK_OFF) begin
        if (p_group_left > 0 || (m_gap == 0 && m_dash == 0)) begin
          if (m_off != 0) begin
            p_led = 0;
            arm_hold(int'(m_off) - int'(p_foff));
            return;
          end
          if (p_group_left > 0 && m_on != 0) begin
            p_phase = lbpe_pkg::PH_BLINK_ON;
            continue;
          end
        end
        p_phase = lbpe_pkg::PH_BEGIN_GAP;
        ph = lbpe_pkg::PH_BEGIN_GAP;
      end
      if (ph == lbpe_pkg::PH_BEGIN_GAP) begin
        p_group_left = group_reload_val();
        if (m_gap != 0) begin
          p_led = 0;
          arm_hold(m_gap);
          return;
        end
        p_phase = lbpe_pkg::PH_BEGIN_DASH;
        ph = lbpe_pkg::PH_BEGIN_DASH;
      end
      if (ph == lbpe_pkg::PH_BEGIN_DASH) begin
        if (m_dash != 0) begin
          p_led = advance_color();
          arm_hold(m_dash);
          return;
        end
        p_phase = lbpe_pkg::PH_BEGIN_GAP2;
        ph = lbpe_pkg::PH_BEGIN_GAP2;
      end
      if (ph == lbpe_pkg::PH_BEGIN_GAP2) begin
        if (m_dash != 0 && m_gap != 0) begin
          p_led = 0;
          arm_hold(m_gap);
          return;
        end
        p_phase = lbpe_pkg::PH_BLINK_ON;
        continue;
      end
      if (p_phase > lbpe_pkg::PH_IN_GAP2) begin
        p_phase = lbpe_pkg::PH_DISABLED;
        return;
      end
      if (p_hold == 0 || p_elapsed < p_hold) return;
      p_elapsed = 0;
      if (p_phase == lbpe_pkg::PH_IN_GAP2 ||
          (p_phase == lbpe_pkg::PH_OFF && p_group_left > 0))
        p_phase = (m_on != 0) ? lbpe_pkg::PH_BLINK_ON
                : ((m_dash != 0) ? lbpe_pkg::PH_BEGIN_DASH : lbpe_pkg::PH_BEGIN_GAP);
      else if (p_phase == lbpe_pkg::PH_OFF) p_phase = lbpe_pkg::PH_BEGIN_GAP;
      else p_phase = p_phase + 4'd1;
    end
  endtask

  task automatic predict_led(blink_cmd_t c);
    if (c.op == lbpe_pkg::OP_TICK) begin
      if (m_fadep != 0) fade_step();
      walk_phases();
      if (p_ftick < 12'd4095) p_ftick++;
      if (p_elapsed < 8'd255) p_elapsed++;
    end else if (c.op == lbpe_pkg::OP_RESTART) restart_pattern();
    else if (c.op == lbpe_pkg::OP_WRITE) begin
      if (int'(c.slot) < lbpe_pkg::MaxColors) p_table[c.slot] = {c.r, c.g, c.b};
      restart_pattern();
    end
    expected_leds.push_back({p_led[23:16], p_led[15:8], p_led[7:0], p_phase, p_foff});
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_led({opcode, slot, red_in, green_in, blue_in});
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && (in_valid && !in_stall) && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        blink_cmd_t nx;
        nx = pending_items[0];
        in_valid <= 1'b1;
        {opcode, slot, red_in, green_in, blue_in} <= nx;
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int out_hold = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        led_state_t e;
        results_seen++;
        if (expected_leds.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          e = expected_leds.pop_front();
          if (led_red !== e.r) begin
            $error("led_red exp %0d got %0d", e.r, led_red); errors++;
          end
          if (led_green !== e.g) begin
            $error("led_green exp %0d got %0d", e.g, led_green); errors++;
          end
          if (led_blue !== e.b) begin
            $error("led_blue exp %0d got %0d", e.b, led_blue); errors++;
          end
          if (phase !== e.ph) begin
            $error("phase exp %0d got %0d", e.ph, phase); errors++;
          end
          if (fade_level !== e.fade) begin
            $error("fade_level exp %0d got %0d", e.fade, fade_level); errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_hold <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lbpe_pkg::REG_ON: m_on = val;
      lbpe_pkg::REG_OFF: m_off = val;
      lbpe_pkg::REG_GAP: m_gap = val;
      lbpe_pkg::REG_DASH: m_dash = val;
      lbpe_pkg::REG_GROUP: m_group = val;
      lbpe_pkg::REG_BLEND: m_blend = val;
      lbpe_pkg::REG_FADE: m_fadep = val;
      lbpe_pkg::REG_COLORS: m_ncol = val[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_leds.size() != 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_item(logic [1:0] op);
    pending_items.push_back({op, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  task automatic run_setting(logic [7:0] v[8], int n);
    for (int k = 0; k < 8; k++) write_reg(3'(k), v[k]);
    add_item(lbpe_pkg::OP_RESTART);
    for (int k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 88) add_item(lbpe_pkg::OP_TICK);
      else if (sel < 93) add_item(lbpe_pkg::OP_RESTART);
      else if (sel < 98) add_item(lbpe_pkg::OP_WRITE);
      else add_item(lbpe_pkg::OP_NOP);
    end
    drain();
  endtask

  initial begin
    logic [7:0] v[8];
    m_on = 0; m_off = 0; m_gap = 0; m_dash = 0; m_group = 0; m_blend = 0;
    m_fadep = 0; m_ncol = 0;
    p_phase = lbpe_pkg::PH_DISABLED; p_group_left = 0; p_pos = 0; p_pos_ok = 0;
    for (int k = 0; k < lbpe_pkg::MaxColors; k++) p_table[k] = 0;
    p_hold = 0; p_elapsed = 0; p_ftick = 0; p_fstep = 0; p_foff = 0;
    p_bcur = 0; p_btgt = 0; p_led = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: a tick with no colours, unused opcode, table extremes
    add_item(lbpe_pkg::OP_TICK);
    add_item(lbpe_pkg::OP_NOP);
    pending_items.push_back({lbpe_pkg::OP_WRITE, 3'd0, 8'hFF, 8'h00, 8'hFF});
    pending_items.push_back({lbpe_pkg::OP_WRITE, 3'd7, 8'h00, 8'hFF, 8'h00});
    drain();
    v = '{8'd2, 8'd1, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3};
    for (int k = 0; k < 4; k++) pending_items.push_back({lbpe_pkg::OP_WRITE, 3'(k),
                                                         8'(k * 60), 8'(255 - k), 8'(k)});
    drain();
    run_setting(v, 16);
    // all timers zero: the restart disables the pattern
    v = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd15};
    run_setting(v, 6);
    v = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd8};
    run_setting(v, 6);
    v = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd8};
    run_setting(v, 8);
    // random settings; mostly short timers so the phases cycle
    for (int s = 0; s < 24; s++) begin
      for (int k = 0; k < 7; k++)
        v[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) v[5] = 8'($urandom_range(1, 80));
      if ($urandom_range(0, 3) == 0) v[6] = 8'($urandom_range(1, 2));
      v[7] = 8'($urandom_range(0, 15));
      if (s == 23) quiet = 1;
      run_setting(v, 70);
    end
    $display("Ran %0d results over 28 register settings, incl. blend, fade, dash and gaps.",
             results_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== led_blink_pattern_engine_unit.f =====
rtl/lbpe_pkg.sv
rtl/lbpe_ctrl.sv
rtl/lbpe_dp.sv
rtl/led_blink_pattern_engine_unit.sv
tb/sv/tb_led_blink_pattern_engine_unit.sv
